// File: src/quic_connection_credit_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// quic connection credit tracker - assertion macros
// shared assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef QUIC_CONNECTION_CREDIT_TRACKER_CORE_DEFINES_SVH
`define QUIC_CONNECTION_CREDIT_TRACKER_CORE_DEFINES_SVH

// checked only outside reset
`define QCCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define QCCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/qcct_pkg.sv
// ----------------------------------------------------------------------------
// qcct_pkg
// types, codes and helpers of the quic connection credit tracker
// ----------------------------------------------------------------------------
package qcct_pkg;

    localparam int CNT_W  = 62;
    localparam int SCNT_W = 60;

    localparam logic [CNT_W-1:0]  MAX62 = {CNT_W{1'b1}};
    localparam logic [SCNT_W-1:0] MAX60 = {SCNT_W{1'b1}};

    // actions
    localparam logic [3:0] ACT_INIT        = 4'd0;
    localparam logic [3:0] ACT_ADD_SENT    = 4'd1;
    localparam logic [3:0] ACT_RAISE_SEND  = 4'd2;
    localparam logic [3:0] ACT_CHECK_SEND  = 4'd3;
    localparam logic [3:0] ACT_ADD_RECV    = 4'd4;
    localparam logic [3:0] ACT_CHECK_RECV  = 4'd5;
    localparam logic [3:0] ACT_RAISE_STRM  = 4'd6;
    localparam logic [3:0] ACT_OPEN_STRM   = 4'd7;
    localparam logic [3:0] ACT_PEER_STRM   = 4'd8;

    // frame kinds
    localparam logic [2:0] FRAME_NONE          = 3'd0;
    localparam logic [2:0] FRAME_DATA_BLOCKED  = 3'd1;
    localparam logic [2:0] FRAME_MAX_DATA      = 3'd2;
    localparam logic [2:0] FRAME_STRM_BLK_BIDI = 3'd3;
    localparam logic [2:0] FRAME_STRM_BLK_UNI  = 3'd4;
    localparam logic [2:0] FRAME_MAX_STRM_BIDI = 3'd5;
    localparam logic [2:0] FRAME_MAX_STRM_UNI  = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_DATA    = 3'd0;
    localparam logic [2:0] CFG_MAX_BIDI    = 3'd1;
    localparam logic [2:0] CFG_MAX_UNI     = 3'd2;
    localparam logic [2:0] CFG_IS_SERVER   = 3'd3;
    localparam logic [2:0] CFG_DATA_LOW    = 3'd4;
    localparam logic [2:0] CFG_DATA_STEP   = 3'd5;
    localparam logic [2:0] CFG_STRM_LOW    = 3'd6;
    localparam logic [2:0] CFG_STRM_STEP   = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 62;

    typedef struct packed {
        logic [61:0] init_max_data;
        logic [60:0] init_max_bidi;
        logic [60:0] init_max_uni;
        logic        is_server;
        logic [31:0] data_low_mark;
        logic [31:0] data_grant_step;
        logic [7:0]  stream_low_mark;
        logic [7:0]  stream_grant_step;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] byte_count;
        logic [61:0] new_limit;
        logic        direction;
        logic [61:0] peer_stream_id;
    } t_item;

    typedef struct packed {
        logic        allowed;
        logic [2:0]  frame_kind;
        logic [61:0] frame_value;
        logic [61:0] sendable_bytes;
        logic [61:0] opened_stream_id;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_add62(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? MAX62 : s[CNT_W-1:0];
    endfunction

endpackage

// File: src/qcct_cfg.sv
// ----------------------------------------------------------------------------
// qcct_cfg
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module qcct_cfg
    import qcct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_max_data     <= 62'd1048576;
            r_cfg.init_max_bidi     <= 61'd100;
            r_cfg.init_max_uni      <= 61'd100;
            r_cfg.is_server         <= 1'b0;
            r_cfg.data_low_mark     <= 32'd8912;
            r_cfg.data_grant_step   <= 32'd8912;
            r_cfg.stream_low_mark   <= 8'd4;
            r_cfg.stream_grant_step <= 8'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DATA:  r_cfg.init_max_data     <= i_cfg_data;
                CFG_MAX_BIDI:  r_cfg.init_max_bidi     <= i_cfg_data[60:0];
                CFG_MAX_UNI:   r_cfg.init_max_uni      <= i_cfg_data[60:0];
                CFG_IS_SERVER: r_cfg.is_server         <= i_cfg_data[0];
                CFG_DATA_LOW:  r_cfg.data_low_mark     <= i_cfg_data[31:0];
                CFG_DATA_STEP: r_cfg.data_grant_step   <= i_cfg_data[31:0];
                CFG_STRM_LOW:  r_cfg.stream_low_mark   <= i_cfg_data[7:0];
                CFG_STRM_STEP: r_cfg.stream_grant_step <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/qcct_engine.sv
// ----------------------------------------------------------------------------
// qcct_engine
// credit state and single-pass update, result registered per transaction
// ----------------------------------------------------------------------------
module qcct_engine
    import qcct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [CNT_W-1:0]  r_bytes_sent, n_bytes_sent;
    logic [CNT_W-1:0]  r_bytes_recv, n_bytes_recv;
    logic [CNT_W-1:0]  r_send_limit, n_send_limit;
    logic [CNT_W-1:0]  r_recv_limit, n_recv_limit;
    logic [CNT_W-1:0]  r_local_bidi, n_local_bidi;
    logic [CNT_W-1:0]  r_local_uni,  n_local_uni;
    logic [CNT_W-1:0]  r_peer_bidi,  n_peer_bidi;
    logic [CNT_W-1:0]  r_peer_uni,   n_peer_uni;
    logic [SCNT_W-1:0] r_bidi_cnt,   n_bidi_cnt;
    logic [SCNT_W-1:0] r_uni_cnt,    n_uni_cnt;
    logic [CNT_W-1:0]  r_last_bidi,  n_last_bidi;
    logic [CNT_W-1:0]  r_last_uni,   n_last_uni;
    t_result           r_result,     n_result;

    logic              w_send_short, w_send_low;
    logic [CNT_W-1:0]  w_send_left;
    logic              w_recv_short, w_recv_low;
    logic [CNT_W-1:0]  w_recv_left, w_recv_grant;
    logic [SCNT_W-1:0] w_ctr, w_ctr_next;
    logic [CNT_W-1:0]  w_limv, w_open_left;
    logic              w_open_short, w_open_low;
    logic              w_uni;
    logic [CNT_W-1:0]  w_last_old, w_last_new, w_idx, w_limp, w_peer_left, w_peer_grant;
    logic              w_peer_short, w_peer_low;

    // data credit
    assign w_send_short = r_bytes_sent >= r_send_limit;
    assign w_send_left  = r_send_limit - r_bytes_sent;
    assign w_send_low   = w_send_left < {30'd0, i_cfg.data_low_mark};
    assign w_recv_short = r_bytes_recv >= r_recv_limit;
    assign w_recv_left  = r_recv_limit - r_bytes_recv;
    assign w_recv_low   = w_recv_left < {30'd0, i_cfg.data_low_mark};
    assign w_recv_grant = sat_add62(r_recv_limit, {30'd0, i_cfg.data_grant_step});

    // local stream open
    assign w_ctr        = i_item.direction ? r_uni_cnt : r_bidi_cnt;
    assign w_ctr_next   = (w_ctr != MAX60) ? w_ctr + 1'b1 : w_ctr;
    assign w_limv       = i_item.direction ? r_local_uni : r_local_bidi;
    assign w_open_short = {2'd0, w_ctr} >= w_limv;
    assign w_open_left  = w_limv - {2'd0, w_ctr};
    assign w_open_low   = w_open_left < {54'd0, i_cfg.stream_low_mark};

    // peer stream check
    assign w_uni        = i_item.peer_stream_id[1];
    assign w_last_old   = w_uni ? r_last_uni : r_last_bidi;
    assign w_last_new   = (i_item.peer_stream_id != '0) ? i_item.peer_stream_id : w_last_old;
    assign w_idx        = {2'd0, w_last_new[CNT_W-1:2]};
    assign w_limp       = w_uni ? r_peer_uni : r_peer_bidi;
    assign w_peer_short = w_idx >= w_limp;
    assign w_peer_left  = w_limp - w_idx;
    assign w_peer_low   = w_peer_left < {54'd0, i_cfg.stream_low_mark};
    assign w_peer_grant = sat_add62(w_limp, {54'd0, i_cfg.stream_grant_step});

    always_comb begin
        n_bytes_sent = r_bytes_sent;
        n_bytes_recv = r_bytes_recv;
        n_send_limit = r_send_limit;
        n_recv_limit = r_recv_limit;
        n_local_bidi = r_local_bidi;
        n_local_uni  = r_local_uni;
        n_peer_bidi  = r_peer_bidi;
        n_peer_uni   = r_peer_uni;
        n_bidi_cnt   = r_bidi_cnt;
        n_uni_cnt    = r_uni_cnt;
        n_last_bidi  = r_last_bidi;
        n_last_uni   = r_last_uni;

        n_result.allowed          = 1'b1;
        n_result.frame_kind       = FRAME_NONE;
        n_result.frame_value      = '0;
        n_result.sendable_bytes   = '0;
        n_result.opened_stream_id = '0;

        case (i_item.action)
            ACT_INIT: begin
                n_send_limit = i_cfg.init_max_data;
                n_recv_limit = i_cfg.init_max_data;
                n_local_bidi = {1'b0, i_cfg.init_max_bidi};
                n_peer_bidi  = {1'b0, i_cfg.init_max_bidi};
                n_local_uni  = {1'b0, i_cfg.init_max_uni};
                n_peer_uni   = {1'b0, i_cfg.init_max_uni};
            end
            ACT_ADD_SENT: begin
                n_bytes_sent = sat_add62(r_bytes_sent, {30'd0, i_item.byte_count});
            end
            ACT_RAISE_SEND: begin
                if (r_send_limit < i_item.new_limit) begin
                    n_send_limit = i_item.new_limit;
                end
            end
            ACT_CHECK_SEND: begin
                if (w_send_short) begin
                    n_result.allowed     = 1'b0;
                    n_result.frame_kind  = FRAME_DATA_BLOCKED;
                    n_result.frame_value = r_send_limit;
                end else begin
                    n_result.sendable_bytes = w_send_left;
                    if (w_send_low) begin
                        n_result.frame_kind  = FRAME_DATA_BLOCKED;
                        n_result.frame_value = r_send_limit;
                    end
                end
            end
            ACT_ADD_RECV: begin
                n_bytes_recv = sat_add62(r_bytes_recv, {30'd0, i_item.byte_count});
            end
            ACT_CHECK_RECV: begin
                if (w_recv_short) begin
                    n_result.allowed = 1'b0;
                end else if (w_recv_low) begin
                    n_recv_limit         = w_recv_grant;
                    n_result.frame_kind  = FRAME_MAX_DATA;
                    n_result.frame_value = w_recv_grant;
                end
            end
            ACT_RAISE_STRM: begin
                if (i_item.direction) begin
                    if (r_local_uni < i_item.new_limit) begin
                        n_local_uni = i_item.new_limit;
                    end
                end else begin
                    if (r_local_bidi < i_item.new_limit) begin
                        n_local_bidi = i_item.new_limit;
                    end
                end
            end
            ACT_OPEN_STRM: begin
                n_result.opened_stream_id = {w_ctr, i_item.direction, i_cfg.is_server};
                if (i_item.direction) begin
                    n_uni_cnt = w_ctr_next;
                end else begin
                    n_bidi_cnt = w_ctr_next;
                end
                if (w_open_short || w_open_low) begin
                    n_result.allowed     = !w_open_short;
                    n_result.frame_kind  = i_item.direction ? FRAME_STRM_BLK_UNI
                                                            : FRAME_STRM_BLK_BIDI;
                    n_result.frame_value = w_limv;
                end
            end
            ACT_PEER_STRM: begin
                if (w_uni) begin
                    n_last_uni = w_last_new;
                end else begin
                    n_last_bidi = w_last_new;
                end
                if (w_peer_short) begin
                    n_result.allowed = 1'b0;
                end else if (w_peer_low) begin
                    if (w_uni) begin
                        n_peer_uni = w_peer_grant;
                    end else begin
                        n_peer_bidi = w_peer_grant;
                    end
                    n_result.frame_kind  = w_uni ? FRAME_MAX_STRM_UNI : FRAME_MAX_STRM_BIDI;
                    n_result.frame_value = w_peer_grant;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_sent <= '0;
            r_bytes_recv <= '0;
            r_send_limit <= '0;
            r_recv_limit <= '0;
            r_local_bidi <= '0;
            r_local_uni  <= '0;
            r_peer_bidi  <= '0;
            r_peer_uni   <= '0;
            r_bidi_cnt   <= '0;
            r_uni_cnt    <= '0;
            r_last_bidi  <= '0;
            r_last_uni   <= '0;
        end else if (i_adv) begin
            r_bytes_sent <= n_bytes_sent;
            r_bytes_recv <= n_bytes_recv;
            r_send_limit <= n_send_limit;
            r_recv_limit <= n_recv_limit;
            r_local_bidi <= n_local_bidi;
            r_local_uni  <= n_local_uni;
            r_peer_bidi  <= n_peer_bidi;
            r_peer_uni   <= n_peer_uni;
            r_bidi_cnt   <= n_bidi_cnt;
            r_uni_cnt    <= n_uni_cnt;
            r_last_bidi  <= n_last_bidi;
            r_last_uni   <= n_last_uni;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// File: src/quic_connection_credit_tracker_core.sv
// ----------------------------------------------------------------------------
// quic_connection_credit_tracker_core
// quic connection-level flow control credit tracker, one event per transaction
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries one event: action, byte
//   count, announced limit, stream direction and peer stream id
//   output channel (o_out_valid / i_out_ready) returns exactly one result per
//   event: allowed flag, frame kind and value, sendable bytes, opened stream id
//   configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while the block is idle; action init loads the limits
//   an event waits in the input register and its result in the result register
//   throughput: 1 event per cycle while the receiver takes results; the state
//   update between the input register and the result register is combinational
//   a stalled receiver holds the result; one more event waits in the input
//   register, then o_in_ready drops until the result is taken
//   reset (synchronous, active low) clears all counters and limits to zero and
//   loads the default configuration; checks fail until init
// ----------------------------------------------------------------------------
module quic_connection_credit_tracker_core
    import qcct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [3:0]            i_action,
    input  logic [31:0]           i_byte_count,
    input  logic [61:0]           i_new_limit,
    input  logic                  i_direction,
    input  logic [61:0]           i_peer_stream_id,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_allowed,
    output logic [2:0]            o_frame_kind,
    output logic [61:0]           o_frame_value,
    output logic [61:0]           o_sendable_bytes,
    output logic [61:0]           o_opened_stream_id
);

    t_cfg    w_cfg;
    t_result w_result;
    t_item   r_item;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.action         <= i_action;
            r_item.byte_count     <= i_byte_count;
            r_item.new_limit      <= i_new_limit;
            r_item.direction      <= i_direction;
            r_item.peer_stream_id <= i_peer_stream_id;
        end
    end

    qcct_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    qcct_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_out_valid        = r_out_valid;
    assign o_allowed          = w_result.allowed;
    assign o_frame_kind       = w_result.frame_kind;
    assign o_frame_value      = w_result.frame_value;
    assign o_sendable_bytes   = w_result.sendable_bytes;
    assign o_opened_stream_id = w_result.opened_stream_id;

endmodule

// File: src/qcct_checker.sv
// ----------------------------------------------------------------------------
// qcct_checker
// port-level assertions for the credit tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "quic_connection_credit_tracker_core_defines.svh"

module qcct_checker
    import qcct_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_allowed,
    input logic [2:0]  o_frame_kind,
    input logic [61:0] o_frame_value,
    input logic [61:0] o_sendable_bytes,
    input logic [61:0] o_opened_stream_id
);

    // result holds while the receiver stalls
    `QCCT_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_value) && $stable(o_frame_kind), "result changed while stalled")

    // no result survives reset
    `QCCT_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // no frame means no frame value
    `QCCT_ASSERT(a_none_zero, o_out_valid && o_frame_kind == FRAME_NONE |-> o_frame_value == '0, "frame value without frame")

    // sendable bytes only on a passing send check
    `QCCT_ASSERT(a_sendable, o_out_valid && o_sendable_bytes != '0 |-> o_allowed && o_opened_stream_id == '0, "sendable bytes on wrong result")

endmodule

bind quic_connection_credit_tracker_core qcct_checker u_qcct_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_allowed          (o_allowed),
    .o_frame_kind       (o_frame_kind),
    .o_frame_value      (o_frame_value),
    .o_sendable_bytes   (o_sendable_bytes),
    .o_opened_stream_id (o_opened_stream_id)
);

// File: verif/qcct_tb_pkg.sv
// ----------------------------------------------------------------------------
// qcct_tb_pkg
// scoreboard of the credit tracker bench: mirrors the counters, limits and
// configuration of the block, predicts one result per accepted event and
// checks the results in order
// ----------------------------------------------------------------------------
package qcct_tb_pkg;

    import qcct_pkg::*;

    class credit_tracker_mirror;

        logic [61:0] cfg_max_data;
        logic [60:0] cfg_max_bidi;
        logic [60:0] cfg_max_uni;
        logic        cfg_server;
        logic [31:0] cfg_data_low;
        logic [31:0] cfg_data_step;
        logic [7:0]  cfg_strm_low;
        logic [7:0]  cfg_strm_step;

        logic [61:0] bytes_sent;
        logic [61:0] bytes_recvd;
        logic [61:0] send_limit;
        logic [61:0] recv_limit;
        logic [61:0] local_bidi_limit;
        logic [61:0] local_uni_limit;
        logic [61:0] peer_bidi_limit;
        logic [61:0] peer_uni_limit;
        logic [59:0] next_bidi;
        logic [59:0] next_uni;
        logic [61:0] peer_last_bidi;
        logic [61:0] peer_last_uni;

        t_result owed_results[$];
        int      failures;

        function new();
            cfg_max_data     = 62'd1048576;
            cfg_max_bidi     = 61'd100;
            cfg_max_uni      = 61'd100;
            cfg_server       = 1'b0;
            cfg_data_low     = 32'd8912;
            cfg_data_step    = 32'd8912;
            cfg_strm_low     = 8'd4;
            cfg_strm_step    = 8'd8;
            bytes_sent       = '0;
            bytes_recvd      = '0;
            send_limit       = '0;
            recv_limit       = '0;
            local_bidi_limit = '0;
            local_uni_limit  = '0;
            peer_bidi_limit  = '0;
            peer_uni_limit   = '0;
            next_bidi        = '0;
            next_uni         = '0;
            peer_last_bidi   = '0;
            peer_last_uni    = '0;
            failures         = 0;
        endfunction

        function logic [61:0] clamp_sum(logic [61:0] a, logic [61:0] b);
            if (a > MAX62 - b) return MAX62;
            return a + b;
        endfunction

        function void set_reg(logic [2:0] idx, logic [61:0] data);
            case (idx)
                CFG_MAX_DATA:  cfg_max_data  = data;
                CFG_MAX_BIDI:  cfg_max_bidi  = data[60:0];
                CFG_MAX_UNI:   cfg_max_uni   = data[60:0];
                CFG_IS_SERVER: cfg_server    = data[0];
                CFG_DATA_LOW:  cfg_data_low  = data[31:0];
                CFG_DATA_STEP: cfg_data_step = data[31:0];
                CFG_STRM_LOW:  cfg_strm_low  = data[7:0];
                CFG_STRM_STEP: cfg_strm_step = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // accepted event: update the mirrored state and queue its result
        function void note_event(t_item ev);
            t_result     r;
            logic [61:0] lim;
            logic [61:0] idx;
            logic [59:0] n;
            logic        uni;
            r         = '0;
            r.allowed = 1'b1;
            case (ev.action)
                ACT_INIT: begin
                    send_limit       = cfg_max_data;
                    recv_limit       = cfg_max_data;
                    local_bidi_limit = {1'b0, cfg_max_bidi};
                    peer_bidi_limit  = {1'b0, cfg_max_bidi};
                    local_uni_limit  = {1'b0, cfg_max_uni};
                    peer_uni_limit   = {1'b0, cfg_max_uni};
                end
                ACT_ADD_SENT: bytes_sent = clamp_sum(bytes_sent, {30'd0, ev.byte_count});
                ACT_RAISE_SEND: begin
                    if (send_limit < ev.new_limit) send_limit = ev.new_limit;
                end
                ACT_CHECK_SEND: begin
                    if (bytes_sent >= send_limit) begin
                        r.allowed     = 1'b0;
                        r.frame_kind  = FRAME_DATA_BLOCKED;
                        r.frame_value = send_limit;
                    end else begin
                        r.sendable_bytes = send_limit - bytes_sent;
                        if (r.sendable_bytes < {30'd0, cfg_data_low}) begin
                            r.frame_kind  = FRAME_DATA_BLOCKED;
                            r.frame_value = send_limit;
                        end
                    end
                end
                ACT_ADD_RECV: bytes_recvd = clamp_sum(bytes_recvd, {30'd0, ev.byte_count});
                ACT_CHECK_RECV: begin
                    if (bytes_recvd >= recv_limit) begin
                        r.allowed = 1'b0;
                    end else if (recv_limit - bytes_recvd < {30'd0, cfg_data_low}) begin
                        recv_limit    = clamp_sum(recv_limit, {30'd0, cfg_data_step});
                        r.frame_kind  = FRAME_MAX_DATA;
                        r.frame_value = recv_limit;
                    end
                end
                ACT_RAISE_STRM: begin
                    if (ev.direction) begin
                        if (local_uni_limit < ev.new_limit) local_uni_limit = ev.new_limit;
                    end else begin
                        if (local_bidi_limit < ev.new_limit) local_bidi_limit = ev.new_limit;
                    end
                end
                ACT_OPEN_STRM: begin
                    n   = ev.direction ? next_uni : next_bidi;
                    lim = ev.direction ? local_uni_limit : local_bidi_limit;
                    r.opened_stream_id = {n, ev.direction, cfg_server};
                    if (n != MAX60) begin
                        if (ev.direction) next_uni = n + 60'd1;
                        else next_bidi = n + 60'd1;
                    end
                    if ({2'b00, n} >= lim) begin
                        r.allowed     = 1'b0;
                        r.frame_kind  = ev.direction ? FRAME_STRM_BLK_UNI : FRAME_STRM_BLK_BIDI;
                        r.frame_value = lim;
                    end else if (lim - {2'b00, n} < {54'd0, cfg_strm_low}) begin
                        r.frame_kind  = ev.direction ? FRAME_STRM_BLK_UNI : FRAME_STRM_BLK_BIDI;
                        r.frame_value = lim;
                    end
                end
                ACT_PEER_STRM: begin
                    uni = ev.peer_stream_id[1];
                    if (ev.peer_stream_id != '0) begin
                        if (uni) peer_last_uni = ev.peer_stream_id;
                        else peer_last_bidi = ev.peer_stream_id;
                    end
                    idx = (uni ? peer_last_uni : peer_last_bidi) >> 2;
                    lim = uni ? peer_uni_limit : peer_bidi_limit;
                    if (idx >= lim) begin
                        r.allowed = 1'b0;
                    end else if (lim - idx < {54'd0, cfg_strm_low}) begin
                        lim = clamp_sum(lim, {54'd0, cfg_strm_step});
                        if (uni) peer_uni_limit = lim;
                        else peer_bidi_limit = lim;
                        r.frame_kind  = uni ? FRAME_MAX_STRM_UNI : FRAME_MAX_STRM_BIDI;
                        r.frame_value = lim;
                    end
                end
                default: ;
            endcase
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $error("result transaction with no event outstanding");
                failures++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("allowed", 64'(want.allowed), 64'(got.allowed));
            compare_field("frame_kind", 64'(want.frame_kind), 64'(got.frame_kind));
            compare_field("frame_value", 64'(want.frame_value), 64'(got.frame_value));
            compare_field("sendable_bytes", 64'(want.sendable_bytes),
                          64'(got.sendable_bytes));
            compare_field("opened_stream_id", 64'(want.opened_stream_id),
                          64'(got.opened_stream_id));
        endfunction

    endclass

endpackage

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// bench of the quic connection credit tracker: directed events around reset,
// init and the limit edges, then random event streams under six register
// settings, with random gaps on both channels and results checked in order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qcct_pkg::*;
    import qcct_tb_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [3:0]            i_action         = '0;
    logic [31:0]           i_byte_count     = '0;
    logic [61:0]           i_new_limit      = '0;
    logic                  i_direction      = 1'b0;
    logic [61:0]           i_peer_stream_id = '0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic                  o_allowed;
    logic [2:0]            o_frame_kind;
    logic [61:0]           o_frame_value;
    logic [61:0]           o_sendable_bytes;
    logic [61:0]           o_opened_stream_id;

    credit_tracker_mirror tracker;
    int send_idle = 14;
    int recv_idle = 56;
    int quiet_cycles = 0;

    quic_connection_credit_tracker_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_byte_count       (i_byte_count),
        .i_new_limit        (i_new_limit),
        .i_direction        (i_direction),
        .i_peer_stream_id   (i_peer_stream_id),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_allowed          (o_allowed),
        .o_frame_kind       (o_frame_kind),
        .o_frame_value      (o_frame_value),
        .o_sendable_bytes   (o_sendable_bytes),
        .o_opened_stream_id (o_opened_stream_id)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // transaction monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.note_event({i_action, i_byte_count, i_new_limit, i_direction,
                                    i_peer_stream_id});
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_result({o_allowed, o_frame_kind, o_frame_value,
                                      o_sendable_bytes, o_opened_stream_id});
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [61:0] rand62();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[61:0];
    endfunction

    function automatic t_item event_of(logic [3:0] act, logic [31:0] nbytes,
                                       logic [61:0] lim, logic dir, logic [61:0] pid);
        t_item ev;
        ev.action         = act;
        ev.byte_count     = nbytes;
        ev.new_limit      = lim;
        ev.direction      = dir;
        ev.peer_stream_id = pid;
        return ev;
    endfunction

    // random event, steered by the mirrored state toward the credit edges
    function automatic t_item shape_event();
        t_item       ev;
        int          pick;
        int          sel;
        logic [61:0] lim;
        logic [61:0] idx;
        logic [63:0] span;
        ev.action         = ACT_CHECK_SEND;
        ev.byte_count     = $urandom;
        ev.new_limit      = rand62();
        ev.direction      = 1'($urandom_range(1));
        ev.peer_stream_id = rand62();
        pick = $urandom_range(99);
        sel  = $urandom_range(9);
        if (pick < 3) begin
            ev.action = ACT_INIT;
        end else if (pick < 14) begin
            ev.action = ACT_ADD_SENT;
            if (sel < 7) ev.byte_count = $urandom % (tracker.cfg_data_low / 2 + 32'd100);
            else if (sel == 7) ev.byte_count = '0;
            else if (sel == 8) ev.byte_count = '1;
        end else if (pick < 21) begin
            ev.action = ACT_RAISE_SEND;
            span = 64'(tracker.cfg_data_low) * 2 + 64'd1000;
            if (sel < 7) begin
                ev.new_limit = tracker.clamp_sum(tracker.bytes_sent,
                                                 62'({$urandom, $urandom} % span));
            end else if (sel == 8) begin
                ev.new_limit = tracker.send_limit >> 1;
            end else if (sel == 9) begin
                ev.new_limit = MAX62;
            end
        end else if (pick < 34) begin
            ev.action = ACT_CHECK_SEND;
        end else if (pick < 44) begin
            ev.action = ACT_ADD_RECV;
            lim = (tracker.recv_limit > tracker.bytes_recvd) ?
                  tracker.recv_limit - tracker.bytes_recvd : '0;
            if (sel < 6) begin
                if (lim > 62'hFFFF_FFFF) ev.byte_count = $urandom % (tracker.cfg_data_low + 32'd1);
                else ev.byte_count = 32'({30'd0, $urandom} % (lim + 62'd1));
            end else if (sel < 8) begin
                ev.byte_count = $urandom % (tracker.cfg_data_low / 2 + 32'd100);
            end else if (sel == 8 || $urandom_range(3) != 0) begin
                ev.byte_count = '0;
            end else begin
                ev.byte_count = '1;
            end
        end else if (pick < 57) begin
            ev.action = ACT_CHECK_RECV;
        end else if (pick < 64) begin
            ev.action = ACT_RAISE_STRM;
            lim = {2'b00, (ev.direction ? tracker.next_uni : tracker.next_bidi)};
            if (sel < 9) ev.new_limit = lim + 62'($urandom_range(0, 12));
        end else if (pick < 78) begin
            ev.action = ACT_OPEN_STRM;
        end else if (pick < 95) begin
            ev.action = ACT_PEER_STRM;
            lim = ev.direction ? tracker.peer_uni_limit : tracker.peer_bidi_limit;
            idx = '0;
            if (sel < 5) begin
                if (lim >= 62'(int'(tracker.cfg_strm_low) + 3)) begin
                    idx = lim - 62'($urandom_range(0, int'(tracker.cfg_strm_low) + 3));
                end else begin
                    idx = 62'($urandom_range(0, 8));
                end
            end else if (sel < 7) begin
                idx = ((ev.direction ? tracker.peer_last_uni : tracker.peer_last_bidi) >> 2)
                      + 62'd1;
            end else if (sel < 8) begin
                idx = lim + 62'($urandom_range(0, 2));
            end
            if (sel < 8) begin
                ev.peer_stream_id = {idx[59:0], ev.direction, 1'($urandom_range(1))};
            end else if (sel == 8) begin
                ev.peer_stream_id = '0;
            end
        end else begin
            ev.action = ACT_PEER_STRM + 4'($urandom_range(1, 7));
        end
        return ev;
    endfunction

    task automatic push_event(input t_item ev);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= ev.action;
        i_byte_count     <= ev.byte_count;
        i_new_limit      <= ev.new_limit;
        i_direction      <= ev.direction;
        i_peer_stream_id <= ev.peer_stream_id;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [61:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic configure(input logic [61:0] max_data, input logic [61:0] max_bidi,
                             input logic [61:0] max_uni, input logic [61:0] server,
                             input logic [61:0] data_low, input logic [61:0] data_step,
                             input logic [61:0] strm_low, input logic [61:0] strm_step);
        write_reg(CFG_MAX_DATA, max_data);
        write_reg(CFG_MAX_BIDI, max_bidi);
        write_reg(CFG_MAX_UNI, max_uni);
        write_reg(CFG_IS_SERVER, server);
        write_reg(CFG_DATA_LOW, data_low);
        write_reg(CFG_DATA_STEP, data_step);
        write_reg(CFG_STRM_LOW, strm_low);
        write_reg(CFG_STRM_STEP, strm_step);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        // zero limits before init
        push_event(event_of(ACT_CHECK_SEND, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_CHECK_RECV, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_OPEN_STRM, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_PEER_STRM, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_INIT, '0, '0, 1'b0, '0));
        // send credit exhausted, then opened wide
        push_event(event_of(ACT_ADD_SENT, '1, '0, 1'b0, '0));
        push_event(event_of(ACT_CHECK_SEND, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_RAISE_SEND, '0, MAX62, 1'b0, '0));
        push_event(event_of(ACT_CHECK_SEND, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_RAISE_SEND, '0, 62'd5, 1'b0, '0));
        // receive grant near the limit, then exhaustion
        push_event(event_of(ACT_ADD_RECV, 32'd1048476, '0, 1'b0, '0));
        push_event(event_of(ACT_CHECK_RECV, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_ADD_RECV, '1, '0, 1'b0, '0));
        push_event(event_of(ACT_CHECK_RECV, '0, '0, 1'b0, '0));
        // stream limits and ids
        push_event(event_of(ACT_RAISE_STRM, '0, '0, 1'b1, '0));
        push_event(event_of(ACT_RAISE_STRM, '0, MAX62, 1'b0, '0));
        push_event(event_of(ACT_OPEN_STRM, '0, '0, 1'b1, '0));
        push_event(event_of(ACT_OPEN_STRM, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_PEER_STRM, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_PEER_STRM, '0, '0, 1'b0, 62'd388));
        push_event(event_of(ACT_PEER_STRM, '0, '0, 1'b1, 62'd402));
        push_event(event_of(ACT_PEER_STRM, '0, '0, 1'b1, MAX62));
        // undefined actions
        push_event(event_of(ACT_PEER_STRM + 4'd1, '0, '0, 1'b0, '0));
        push_event(event_of(ACT_PEER_STRM + 4'd7, '1, MAX62, 1'b1, MAX62));
    endtask

    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 14 : (ph < 4) ? 56 : 0;
            recv_idle = (ph < 2) ? 56 : (ph < 4) ? 14 : 0;
            wait_for_results();
            case (ph)
                0: configure(62'd20000, 62'd6, 62'd3, 62'd1, 62'd3000, 62'd5000, 62'd3, 62'd2);
                1: configure(62'd1048576, 62'd100, 62'd100, 62'd0, 62'd8912, 62'd8912,
                             62'd4, 62'd8);
                2: configure('0, '0, '0, '0, '0, '0, '0, '0);
                3: configure(MAX62, 62'd1 << 60, 62'd1 << 60, 62'd1, 62'hFFFF_FFFF,
                             62'hFFFF_FFFF, 62'd255, 62'd255);
                4: configure(rand62(), rand62() >> 2, rand62() >> 2, 62'($urandom_range(1)),
                             62'($urandom), 62'($urandom), 62'($urandom_range(255)),
                             62'($urandom_range(255)));
                default: configure(tracker.clamp_sum(tracker.bytes_recvd,
                                                     62'($urandom_range(0, 200000))),
                                   62'($urandom_range(0, 40)), 62'($urandom_range(0, 40)),
                                   62'($urandom_range(1)), 62'($urandom_range(0, 20000)),
                                   62'($urandom_range(0, 20000)), 62'($urandom_range(255)),
                                   62'($urandom_range(255)));
            endcase
            push_event(event_of(ACT_INIT, '0, '0, 1'b0, '0));
            repeat (215) begin
                if ($urandom_range(199) == 0) wait_for_results();
                push_event(shape_event());
            end
        end
        wait_for_results();
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
